@@ sv/tstd_pkg.sv @@
// Shared types and constants of the touchpad single-tap detector.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package tstd_pkg;

    // Pointer action codes.
    localparam logic [1:0] ACT_DOWN  = 2'd0;
    localparam logic [1:0] ACT_UP    = 2'd1;
    localparam logic [1:0] ACT_MOVE  = 2'd2;
    localparam logic [1:0] ACT_OTHER = 2'd3;

    // Left-button event codes.
    localparam logic BTN_PRESS   = 1'b0;
    localparam logic BTN_RELEASE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TAP_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MOVE_X       = 2'd1;
    localparam logic [1:0] CFG_MOVE_Y       = 2'd2;

    localparam logic [15:0] TAP_INTERVAL_RST = 16'd200;
    localparam logic [15:0] MOVE_X_RST       = 16'd10;
    localparam logic [15:0] MOVE_Y_RST       = 16'd10;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_DOWN = 2'b10
    } tstd_phase_t;

    typedef struct packed {
        logic [1:0]         pointer_action;
        logic [3:0]         pointer_id;
        logic               id_in_list;
        logic [3:0]         finger_count;
        logic               item_present;
        logic [3:0]         item_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [47:0]        event_time;
        logic [15:0]        source_device;
    } tstd_event_t;

    typedef struct packed {
        logic [15:0] max_tap_interval_ms;
        logic [15:0] max_move_x;
        logic [15:0] max_move_y;
    } tstd_cfg_t;

    typedef struct packed {
        logic [15:0] device;
        logic [47:0] stamp;
    } tstd_click_t;

endpackage

@@ sv/tstd_cfg_regs.sv @@
// Configuration register file of the touchpad single-tap detector.
// Depends on tstd_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module tstd_cfg_regs
    import tstd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output tstd_cfg_t   cfg_o
);

    tstd_cfg_t cfg_reg;
    tstd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TAP_INTERVAL: cfg_next.max_tap_interval_ms = cfg_data;
                CFG_MOVE_X:       cfg_next.max_move_x = cfg_data;
                CFG_MOVE_Y:       cfg_next.max_move_y = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_tap_interval_ms <= TAP_INTERVAL_RST;
            cfg_reg.max_move_x          <= MOVE_X_RST;
            cfg_reg.max_move_y          <= MOVE_Y_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/tstd_tap_fsm.sv @@
// Tap recognition state machine: phase, tracked id, down time and position.
// Depends on tstd_pkg for the event, configuration and phase types.
`timescale 1ns / 1ps

module tstd_tap_fsm
    import tstd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tstd_event_t ev_i,
    input  logic        fire_i,
    input  tstd_cfg_t   cfg_i,
    output logic        click_o
);

    tstd_phase_t        phase_reg, phase_next;
    logic [3:0]         tracked_id_reg, tracked_id_next;
    logic [47:0]        down_time_reg, down_time_next;
    logic signed [15:0] down_x_reg, down_x_next;
    logic signed [15:0] down_y_reg, down_y_next;

    logic [47:0]        dt;
    logic               in_time;
    logic signed [16:0] dx, dy;
    logic [16:0]        mag_x, mag_y;
    logic               drift_ok;

    // A negative time difference counts as inside the interval.
    assign dt      = ev_i.event_time - down_time_reg;
    assign in_time = dt[47] || (dt[46:0] <= {31'd0, cfg_i.max_tap_interval_ms});

    assign dx    = 17'(ev_i.pos_x) - 17'(down_x_reg);
    assign dy    = 17'(ev_i.pos_y) - 17'(down_y_reg);
    assign mag_x = dx[16] ? 17'(-dx) : 17'(dx);
    assign mag_y = dy[16] ? 17'(-dy) : 17'(dy);
    assign drift_ok = (mag_x <= {1'b0, cfg_i.max_move_x})
                   && (mag_y <= {1'b0, cfg_i.max_move_y});

    always_comb begin
        phase_next      = phase_reg;
        tracked_id_next = tracked_id_reg;
        down_time_next  = down_time_reg;
        down_x_next     = down_x_reg;
        down_y_next     = down_y_reg;
        click_o         = 1'b0;
        if (!ev_i.id_in_list) begin
            phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (ev_i.pointer_action == ACT_DOWN && ev_i.finger_count == 4'd1
                            && ev_i.item_present) begin
                        tracked_id_next = ev_i.item_id;
                        down_time_next  = ev_i.event_time;
                        down_x_next     = ev_i.pos_x;
                        down_y_next     = ev_i.pos_y;
                        phase_next      = PH_DOWN;
                    end
                end
                PH_DOWN: begin
                    unique case (ev_i.pointer_action)
                        ACT_UP: begin
                            phase_next = PH_IDLE;
                            click_o    = (ev_i.finger_count <= 4'd1) && in_time;
                        end
                        ACT_MOVE: begin
                            if (!ev_i.item_present || ev_i.pointer_id != tracked_id_reg
                                    || !drift_ok) begin
                                phase_next = PH_IDLE;
                            end
                        end
                        ACT_DOWN, ACT_OTHER: phase_next = PH_IDLE;
                        default:             phase_next = PH_IDLE;
                    endcase
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tracked_id_reg <= 4'd0;
            down_time_reg  <= 48'd0;
            down_x_reg     <= 16'sd0;
            down_y_reg     <= 16'sd0;
        end else if (fire_i) begin
            phase_reg      <= phase_next;
            tracked_id_reg <= tracked_id_next;
            down_time_reg  <= down_time_next;
            down_x_reg     <= down_x_next;
            down_y_reg     <= down_y_next;
        end
    end

endmodule

@@ sv/tstd_out_buf.sv @@
// Result buffer: holds one click and plays it out as a press then a release.
// Depends on tstd_pkg for the click type and button codes.
`timescale 1ns / 1ps

module tstd_out_buf
    import tstd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_i,
    input  tstd_click_t click_i,
    output logic        free_o,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,
    output logic        m_tlast,
    output tstd_click_t m_click
);

    // Words still to send: two after a load, the last one being the release.
    logic [1:0]  cnt_reg, cnt_next;
    tstd_click_t click_reg;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = (cnt_reg == 2'd1) ? BTN_RELEASE : BTN_PRESS;
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_click  = click_reg;
    assign free_o   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_comb begin
        cnt_next = cnt_reg;
        if (load_i) begin
            cnt_next = 2'd2;
        end else if (m_tvalid && m_tready) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            click_reg <= click_i;
        end
    end

endmodule

@@ sv/touch_single_tap_detector.sv @@
// Touchpad single-tap detector: turns a one-finger tap into a left click.
// Order: an event is registered on acceptance and judged in the next cycle;
// the press word of a click is valid on m_ once its up event is judged and
// loaded into the result buffer, and the release word follows once the press
// has been taken. Throughput: one event per cycle; an up event that makes a
// click waits while the previous click still holds the output. Reset:
// synchronous on aresetn low; idle phase, limits 200 ms / 10 / 10.
`timescale 1ns / 1ps

module touch_single_tap_detector
    import tstd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input event stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: pointer_id[3:0], id_in_list[4], finger_count[8:5],
    // item_present[9], item_id[13:10], pos_x[29:14], pos_y[45:30],
    // event_time[93:46], source_device[109:94], zero pad[111:110].
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Field: pointer_action[1:0].
    input  logic [1:0]             s_tuser,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: out_device[15:0], out_time[63:16].
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Field: button_action[0] (0 press, 1 release).
    output logic                   m_tuser,
    output logic                   m_tlast
);

    tstd_cfg_t   cfg;
    tstd_event_t s_ev;
    tstd_event_t ev_reg;
    logic        ev_valid_reg;
    logic        click;
    logic        out_free;
    logic        consume;
    tstd_click_t click_in;
    tstd_click_t click_out;

    // Unpack the incoming word into its fields.
    always_comb begin
        s_ev.pointer_action = s_tuser;
        s_ev.pointer_id     = s_tdata[3:0];
        s_ev.id_in_list     = s_tdata[4];
        s_ev.finger_count   = s_tdata[8:5];
        s_ev.item_present   = s_tdata[9];
        s_ev.item_id        = s_tdata[13:10];
        s_ev.pos_x          = s_tdata[29:14];
        s_ev.pos_y          = s_tdata[45:30];
        s_ev.event_time     = s_tdata[93:46];
        s_ev.source_device  = s_tdata[109:94];
    end

    tstd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    // The registered event is retired when it produces no click, or when the
    // result buffer can take the click it produces. The input register then
    // refills in the same cycle, so events that make no click flow at one per
    // cycle no matter what the result side is doing.
    assign consume  = ev_valid_reg && (!click || out_free);
    assign s_tready = !ev_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg <= 1'b0;
        end else if (s_tready) begin
            ev_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ev_reg <= s_ev;
        end
    end

    tstd_tap_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ev_i    (ev_reg),
        .fire_i  (consume),
        .cfg_i   (cfg),
        .click_o (click)
    );

    assign click_in.device = ev_reg.source_device;
    assign click_in.stamp  = ev_reg.event_time;

    tstd_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (consume && click),
        .click_i  (click_in),
        .free_o   (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_click  (click_out)
    );

    assign m_tdata = {click_out.stamp, click_out.device};

endmodule
